// ===== src/csfw_pkg.sv =====
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and codes for the counting semaphore with a fifo wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

  // request codes
  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  // result error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_SAT  = 2'd2;

  // width of the configuration write data
  localparam int unsigned CFG_WIDTH = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } csfw_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the request beat
    logic commit;      // finish a request that needs no queue read
    logic rd_en;       // read the queue head
    logic commit_pop;  // finish a release using the head read data
  } csfw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_case;    // signal with at least one waiter queued
    logic out_free;    // output register can take a result this cycle
  } csfw_sts_t;

endpackage

`default_nettype wire

// ===== src/csfw_if.sv =====
// ----------------------------------------------------------------------------
// csfw channel interfaces
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csfw_in_if #(
  parameter int unsigned TID_W = 4
);
  logic             valid;
  logic             ready;
  logic             operation;
  logic [TID_W-1:0] thread_id;

  modport source (output valid, output operation, output thread_id, input ready);
  modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface csfw_out_if #(
  parameter int unsigned TID_W = 4,
  parameter int unsigned CNT_W = 8,
  parameter int unsigned OCC_W = 5
);
  logic             valid;
  logic             ready;
  logic             granted;
  logic             released_valid;
  logic [TID_W-1:0] released_thread;
  logic [CNT_W-1:0] count_value;
  logic [OCC_W-1:0] waiting_count;
  logic [1:0]       error_code;

  modport source (
    output valid, output granted, output released_valid, output released_thread,
    output count_value, output waiting_count, output error_code, input ready
  );
  modport sink (
    input valid, input granted, input released_valid, input released_thread,
    input count_value, input waiting_count, input error_code, output ready
  );
endinterface

interface csfw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/csfw_ram.sv =====
// ----------------------------------------------------------------------------
// csfw_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/csfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// csfw_ctrl
// Request sequencer: capture, execute, and head read for releases.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  csfw_pkg::csfw_sts_t  sts,
  output csfw_pkg::csfw_cmd_t  cmd
);

  csfw_pkg::csfw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csfw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      csfw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = csfw_pkg::S_EXEC;
        end
      end
      csfw_pkg::S_EXEC: begin
        if (sts.pop_case) begin
          cmd.rd_en = 1'b1;
          state_nxt = csfw_pkg::S_POP;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = csfw_pkg::S_IDLE;
        end
      end
      csfw_pkg::S_POP: begin
        // head data sits in the ram read register until the result is taken
        if (sts.out_free) begin
          cmd.commit_pop = 1'b1;
          state_nxt      = csfw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = csfw_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.commit, cmd.rd_en, cmd.commit_pop}))
    else $error("csfw_ctrl: more than one command at once");

  a_read_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> state_r == csfw_pkg::S_POP)
    else $error("csfw_ctrl: head read not followed by release step");

  a_latch_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == csfw_pkg::S_EXEC && !in_ready)
    else $error("csfw_ctrl: captured request not executed");
`endif

endmodule

`default_nettype wire

// ===== src/csfw_dp.sv =====
// ----------------------------------------------------------------------------
// csfw_dp
// Semaphore count, wait queue pointers and storage, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_dp #(
  parameter int unsigned QUEUE_DEPTH     = 16,
  parameter int unsigned THREAD_ID_WIDTH = 4,
  parameter int unsigned COUNT_WIDTH     = 8,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH),
  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  csfw_pkg::csfw_cmd_t                cmd,
  output csfw_pkg::csfw_sts_t                sts,
  input  wire                                in_operation,
  input  wire [THREAD_ID_WIDTH-1:0]          in_thread_id,
  input  wire                                cfg_we,
  input  wire [csfw_pkg::CFG_WIDTH-1:0]      cfg_data,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic                               out_granted,
  output logic                               out_released_valid,
  output logic [THREAD_ID_WIDTH-1:0]         out_released_thread,
  output logic [COUNT_WIDTH-1:0]             out_count_value,
  output logic [OccW-1:0]                    out_waiting_count,
  output logic [1:0]                         out_error_code
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [OccW-1:0]        OccFull  = OccW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0]        IdxLast  = IdxW'(QUEUE_DEPTH - 1);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    next_idx = (i == IdxLast) ? '0 : i + IdxW'(1);
  endfunction

  // request capture
  logic                       op_r, op_nxt;
  logic [THREAD_ID_WIDTH-1:0] tid_r, tid_nxt;

  // semaphore and queue state
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [IdxW-1:0]        head_r, head_nxt;
  logic [IdxW-1:0]        tail_r, tail_nxt;
  logic [OccW-1:0]        occ_r, occ_nxt;

  // result register
  logic                       ovalid_r, ovalid_nxt;
  logic                       grant_r, grant_nxt;
  logic                       relv_r, relv_nxt;
  logic [THREAD_ID_WIDTH-1:0] relt_r, relt_nxt;
  logic [COUNT_WIDTH-1:0]     cntv_r, cntv_nxt;
  logic [OccW-1:0]            wcnt_r, wcnt_nxt;
  logic [1:0]                 err_r, err_nxt;

  logic                       ram_we;
  logic [THREAD_ID_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH+csfw_pkg::CFG_WIDTH-1:0] cfg_ext;

  csfw_ram #(
    .WIDTH (THREAD_ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (tid_r),
    .re    (cmd.rd_en),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign cfg_ext      = {{COUNT_WIDTH{1'b0}}, cfg_data};
  assign sts.pop_case = (op_r == csfw_pkg::OP_SIGNAL) && (occ_r != '0);
  assign sts.out_free = !ovalid_r || out_ready;

  always_comb begin
    op_nxt     = op_r;
    tid_nxt    = tid_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    ram_we     = 1'b0;
    ovalid_nxt = ovalid_r && !out_ready;
    grant_nxt  = grant_r;
    relv_nxt   = relv_r;
    relt_nxt   = relt_r;
    cntv_nxt   = cntv_r;
    wcnt_nxt   = wcnt_r;
    err_nxt    = err_r;

    if (cmd.latch) begin
      op_nxt  = in_operation;
      tid_nxt = in_thread_id;
    end

    if (cmd.commit) begin
      ovalid_nxt = 1'b1;
      grant_nxt  = 1'b0;
      relv_nxt   = 1'b0;
      relt_nxt   = '0;
      err_nxt    = csfw_pkg::ERR_NONE;
      if (op_r == csfw_pkg::OP_WAIT) begin
        if (count_r != '0) begin
          count_nxt = count_r - COUNT_WIDTH'(1);
          grant_nxt = 1'b1;
        end else if (occ_r == OccFull) begin
          err_nxt = csfw_pkg::ERR_FULL;
        end else begin
          ram_we   = 1'b1;
          tail_nxt = next_idx(tail_r);
          occ_nxt  = occ_r + OccW'(1);
        end
      end else begin
        // signal with nobody waiting
        if (count_r == CountMax) begin
          err_nxt = csfw_pkg::ERR_SAT;
        end else begin
          count_nxt = count_r + COUNT_WIDTH'(1);
        end
      end
      cntv_nxt = count_nxt;
      wcnt_nxt = occ_nxt;
    end

    if (cmd.commit_pop) begin
      ovalid_nxt = 1'b1;
      grant_nxt  = 1'b0;
      relv_nxt   = 1'b1;
      relt_nxt   = ram_rdata;
      err_nxt    = csfw_pkg::ERR_NONE;
      head_nxt   = next_idx(head_r);
      occ_nxt    = occ_r - OccW'(1);
      cntv_nxt   = count_r;
      wcnt_nxt   = occ_nxt;
    end

    // register write loads the semaphore count from the write data and empties the queue
    if (cfg_we) begin
      count_nxt = cfg_ext[COUNT_WIDTH-1:0];
      head_nxt  = '0;
      tail_nxt  = '0;
      occ_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    tid_r  <= tid_nxt;
    grant_r <= grant_nxt;
    relv_r <= relv_nxt;
    relt_r <= relt_nxt;
    cntv_r <= cntv_nxt;
    wcnt_r <= wcnt_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid           = ovalid_r;
  assign out_granted         = grant_r;
  assign out_released_valid  = relv_r;
  assign out_released_thread = relt_r;
  assign out_count_value     = cntv_r;
  assign out_waiting_count   = wcnt_r;
  assign out_error_code      = err_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OccFull)
    else $error("csfw_dp: queue occupancy beyond depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_pop && !cfg_we |=> occ_r == $past(occ_r) - OccW'(1))
    else $error("csfw_dp: release did not remove one waiter");

  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && grant_r |-> !relv_r && err_r == csfw_pkg::ERR_NONE)
    else $error("csfw_dp: granted result carries release or error");

  a_relt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !relv_r |-> relt_r == '0)
    else $error("csfw_dp: released thread set with no release");
`endif

endmodule

`default_nettype wire

// ===== src/counting_semaphore_fifo_waiters_core.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// Counting semaphore with a first-in first-out queue of blocked thread ids.
// ----------------------------------------------------------------------------
//  channel   direction  beat payload
//  in_if     sink       operation, thread_id
//  out_if    source     granted, released_valid, released_thread, count_value,
//                       waiting_count, error_code
//  cfg_if    sink       data (initial_count), always ready
//
//  an accepted request is captured, then executed into the result register; a
//  signal that wakes a queued thread first does a registered read of the
//  waiter ram at the queue head. the next request is accepted in the cycle after
//  the result is loaded, while that result may still wait on out_if.ready.
//  a full result register stalls the request in flight. reset (rst_n low,
//  synchronous) zeroes the count and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_waiters_core #(
  parameter int unsigned QUEUE_DEPTH     = 16,
  parameter int unsigned THREAD_ID_WIDTH = 4,
  parameter int unsigned COUNT_WIDTH     = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  csfw_in_if.sink     in_if,
  csfw_out_if.source  out_if,
  csfw_cfg_if.sink    cfg_if
);

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);

  csfw_pkg::csfw_cmd_t cmd;
  csfw_pkg::csfw_sts_t sts;

  logic                       in_ready;
  logic                       out_valid;
  logic                       out_granted;
  logic                       out_released_valid;
  logic [THREAD_ID_WIDTH-1:0] out_released_thread;
  logic [COUNT_WIDTH-1:0]     out_count_value;
  logic [OccW-1:0]            out_waiting_count;
  logic [1:0]                 out_error_code;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;

  assign out_if.valid           = out_valid;
  assign out_if.granted         = out_granted;
  assign out_if.released_valid  = out_released_valid;
  assign out_if.released_thread = out_released_thread;
  assign out_if.count_value     = out_count_value;
  assign out_if.waiting_count   = out_waiting_count;
  assign out_if.error_code      = out_error_code;

  csfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csfw_dp #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .THREAD_ID_WIDTH (THREAD_ID_WIDTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_if.operation),
    .in_thread_id        (in_if.thread_id),
    .cfg_we              (cfg_if.valid),
    .cfg_data            (cfg_if.data),
    .out_ready           (out_if.ready),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_released_valid  (out_released_valid),
    .out_released_thread (out_released_thread),
    .out_count_value     (out_count_value),
    .out_waiting_count   (out_waiting_count),
    .out_error_code      (out_error_code)
  );

endmodule

`default_nettype wire
